[sv/bpu_pkg.sv]
// ----------------------------------------------------------------------------
// BMP pixel unpack package
// Shared codes, widths and the job record passed from the front to the back.
// ----------------------------------------------------------------------------
package bpu_pkg;

  localparam int COORD_W    = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // Pixel format register codes.
  localparam logic [2:0] FMT_1BPP  = 3'd0;
  localparam logic [2:0] FMT_4BPP  = 3'd1;
  localparam logic [2:0] FMT_8BPP  = 3'd2;
  localparam logic [2:0] FMT_24BPP = 3'd3;
  localparam logic [2:0] FMT_32BPP = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_ENABLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd6;

  // Rotation codes.
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  typedef enum logic [1:0] {
    UNPACK_1BPP,
    UNPACK_4BPP,
    UNPACK_8BPP,
    UNPACK_DIRECT
  } unpack_e;

  // One unit of work for the back end: a palette write or a run of pixels
  // from one data byte. For a palette write, data is the palette index; for
  // indexed pixels it is the data byte.
  typedef struct packed {
    logic        is_pixel;
    unpack_e     mode;
    logic [3:0]  count;
    logic [7:0]  data;
    logic [23:0] color;
  } job_t;

endpackage

[sv/bpu_fifo.sv]
// ----------------------------------------------------------------------------
// BMP pixel unpack job queue
// Small first-in first-out buffer between the front and the back end.
// ----------------------------------------------------------------------------
module bpu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[sv/bpu_front.sv]
// ----------------------------------------------------------------------------
// BMP pixel unpack front end
// Accepts requests, tracks row, column and byte position in the padded
// pixel array, and turns each request into at most one job for the back end.
// ----------------------------------------------------------------------------
module bpu_front
  import bpu_pkg::*;
#(
  parameter int DIM_W = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic [2:0]       pixel_format_i,
  input  logic [DIM_W-1:0] width_i,
  input  logic [DIM_W-1:0] height_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  logic [7:0]       palette_index_i,
  input  logic [7:0]       palette_red_i,
  input  logic [7:0]       palette_green_i,
  input  logic [7:0]       palette_blue_i,
  input  logic [7:0]       data_byte_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output job_t             push_job_o,
  output logic [DIM_W-1:0] push_row_o,
  output logic [DIM_W-1:0] push_col_o
);

  localparam int BITS_W = DIM_W + 5;
  localparam int RB_W   = DIM_W + 2;

  unpack_e           mode;
  logic              is_32;
  logic [BITS_W-1:0] row_bits;
  logic [BITS_W:0]   row_bits_rnd;
  logic [RB_W-1:0]   row_bytes;
  logic [DIM_W-1:0]  remaining;
  logic [3:0]        per_byte;
  logic [3:0]        count;
  logic              col_in_row;
  logic              accept;
  logic              pixel_push;

  logic [DIM_W-1:0]  row_q, row_d;
  logic [DIM_W-1:0]  col_q, col_d;
  logic [RB_W-1:0]   bir_q, bir_d;
  logic [1:0]        bip_q, bip_d;
  logic [15:0]       part_q, part_d;
  logic [DIM_W-1:0]  row_inc;

  always_comb begin
    case (pixel_format_i)
      FMT_1BPP:  mode = UNPACK_1BPP;
      FMT_4BPP:  mode = UNPACK_4BPP;
      FMT_24BPP: mode = UNPACK_DIRECT;
      FMT_32BPP: mode = UNPACK_DIRECT;
      default:   mode = UNPACK_8BPP;
    endcase
  end

  assign is_32 = (pixel_format_i == FMT_32BPP);

  // Bits per row, rounded up to whole 32-bit words, gives the padded size.
  always_comb begin
    case (mode)
      UNPACK_1BPP: row_bits = BITS_W'(width_i);
      UNPACK_4BPP: row_bits = BITS_W'(width_i) << 2;
      UNPACK_8BPP: row_bits = BITS_W'(width_i) << 3;
      default: begin
        row_bits = is_32 ? (BITS_W'(width_i) << 5)
                         : ((BITS_W'(width_i) << 4) + (BITS_W'(width_i) << 3));
      end
    endcase
  end

  assign row_bits_rnd = (BITS_W + 1)'(row_bits) + (BITS_W + 1)'(31);
  assign row_bytes    = RB_W'(row_bits_rnd >> 5) << 2;

  always_comb begin
    case (mode)
      UNPACK_1BPP: per_byte = 4'd8;
      UNPACK_4BPP: per_byte = 4'd2;
      default:     per_byte = 4'd1;
    endcase
  end

  assign col_in_row = (col_q < width_i);
  assign remaining  = width_i - col_q;
  assign count      = (remaining < DIM_W'(per_byte)) ? 4'(remaining) : per_byte;
  assign row_inc    = row_q + DIM_W'(1);

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    row_d      = row_q;
    col_d      = col_q;
    bir_d      = bir_q;
    bip_d      = bip_q;
    part_d     = part_q;
    pixel_push = 1'b0;
    if (op_i) begin
      if (col_in_row) begin
        if (mode == UNPACK_DIRECT) begin
          case (bip_q)
            2'd0: begin
              part_d = {8'h00, data_byte_i};
              bip_d  = 2'd1;
            end
            2'd1: begin
              part_d = {data_byte_i, part_q[7:0]};
              bip_d  = 2'd2;
            end
            2'd2: begin
              pixel_push = 1'b1;
              if (is_32) begin
                bip_d = 2'd3;
              end else begin
                bip_d = 2'd0;
                col_d = col_q + DIM_W'(1);
              end
            end
            default: begin
              // Alpha byte of a 32-bit pixel.
              bip_d = 2'd0;
              col_d = col_q + DIM_W'(1);
            end
          endcase
        end else begin
          pixel_push = 1'b1;
          col_d      = col_q + DIM_W'(count);
        end
      end
      bir_d = bir_q + RB_W'(1);
      if (bir_d >= row_bytes) begin
        bir_d  = '0;
        col_d  = '0;
        bip_d  = 2'd0;
        part_d = '0;
        row_d  = (row_inc >= height_i) ? '0 : row_inc;
      end
    end
  end

  assign push_valid_o = in_valid_i & (~op_i | pixel_push);

  always_comb begin
    push_job_o.is_pixel = op_i;
    push_job_o.mode     = mode;
    push_job_o.count    = (mode == UNPACK_DIRECT) ? 4'd1 : count;
    push_job_o.data     = op_i ? data_byte_i : palette_index_i;
    push_job_o.color    = op_i ? {data_byte_i, part_q}
                               : {palette_red_i, palette_green_i, palette_blue_i};
  end

  assign push_row_o = row_q;
  assign push_col_o = col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      bir_q  <= '0;
      bip_q  <= 2'd0;
      part_q <= '0;
    end else if (clear_i) begin
      row_q  <= '0;
      col_q  <= '0;
      bir_q  <= '0;
      bip_q  <= 2'd0;
      part_q <= '0;
    end else if (accept) begin
      row_q  <= row_d;
      col_q  <= col_d;
      bir_q  <= bir_d;
      bip_q  <= bip_d;
      part_q <= part_d;
    end
  end

endmodule

[sv/bpu_back.sv]
// ----------------------------------------------------------------------------
// BMP pixel unpack back end
// Holds the palette, expands jobs into pixels one per cycle unless stalled,
// maps them to rotated screen coordinates and drives the result register.
// ----------------------------------------------------------------------------
module bpu_back
  import bpu_pkg::*;
#(
  parameter int DIM_W         = 13,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  job_t               job_i,
  input  logic [DIM_W-1:0]   row_i,
  input  logic [DIM_W-1:0]   col_i,
  input  logic [DIM_W-1:0]   width_i,
  input  logic [DIM_W-1:0]   height_i,
  input  logic [1:0]         rotation_i,
  input  logic               mirror_enable_i,
  input  logic [13:0]        origin_x_i,
  input  logic [13:0]        origin_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [COORD_W-1:0] screen_x_o,
  output logic [COORD_W-1:0] screen_y_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic               last_of_run_o
);

  localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [23:0]        pal_mem [PALETTE_DEPTH];
  logic [23:0]        pal_rd_q;

  logic [2:0]         k_q;
  logic               advance;
  logic               fire;
  logic               last_pix;
  logic [7:0]         idx;
  logic               idx_ok;
  logic [DIM_W-1:0]   col;
  logic [COORD_W-1:0] ox, oy, wx, hx, ix, jx;
  logic [COORD_W-1:0] x, y;

  logic               out_valid_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [23:0]        color_q;
  logic               use_pal_q;
  logic               black_q;
  logic               last_q;
  logic [23:0]        rgb;

  assign advance     = ~out_valid_q | out_ready_i;
  assign fire        = advance & job_valid_i;
  assign last_pix    = ({1'b0, k_q} + 4'd1) == job_i.count;
  assign job_ready_o = advance & (~job_i.is_pixel | last_pix);

  // Palette index of the current pixel, most significant pixel first.
  always_comb begin
    if (!job_i.is_pixel) begin
      idx = job_i.data;
    end else begin
      case (job_i.mode)
        UNPACK_1BPP: idx = {7'd0, job_i.data[3'd7 - k_q]};
        UNPACK_4BPP: idx = (k_q == 3'd0) ? {4'd0, job_i.data[7:4]}
                                         : {4'd0, job_i.data[3:0]};
        default:     idx = job_i.data;
      endcase
    end
  end

  assign idx_ok = ({1'b0, idx} < 9'(PALETTE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (job_i.is_pixel) begin
        pal_rd_q <= pal_mem[idx[PAL_AW-1:0]];
      end else if (idx_ok) begin
        pal_mem[idx[PAL_AW-1:0]] <= job_i.color;
      end
    end
  end

  assign col = col_i + DIM_W'(k_q);
  assign ox  = COORD_W'(origin_x_i);
  assign oy  = COORD_W'(origin_y_i);
  assign wx  = COORD_W'(width_i);
  assign hx  = COORD_W'(height_i);
  assign ix  = COORD_W'(row_i);
  assign jx  = COORD_W'(col);

  always_comb begin
    case (rotation_i)
      ROT_0: begin
        x = mirror_enable_i ? (ox + wx - jx) : (ox + jx);
        y = oy + hx - ix;
      end
      ROT_90: begin
        x = ox + hx - ix;
        y = mirror_enable_i ? (oy + jx) : (oy + wx - jx);
      end
      ROT_180: begin
        x = mirror_enable_i ? (ox + jx) : (ox + wx - jx);
        y = oy + ix;
      end
      default: begin
        x = ox + ix;
        y = mirror_enable_i ? (oy + wx - jx) : (oy + jx);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      k_q         <= 3'd0;
    end else begin
      if (advance) begin
        out_valid_q <= fire & job_i.is_pixel;
      end
      if (fire && job_i.is_pixel) begin
        k_q <= last_pix ? 3'd0 : k_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && job_i.is_pixel) begin
      x_q       <= x;
      y_q       <= y;
      color_q   <= job_i.color;
      use_pal_q <= (job_i.mode != UNPACK_DIRECT);
      black_q   <= ~idx_ok;
      last_q    <= last_pix;
    end
  end

  always_comb begin
    if (!use_pal_q) begin
      rgb = color_q;
    end else if (black_q) begin
      rgb = '0;
    end else begin
      rgb = pal_rd_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign screen_x_o    = x_q;
  assign screen_y_o    = y_q;
  assign red_o         = rgb[23:16];
  assign green_o       = rgb[15:8];
  assign blue_o        = rgb[7:0];
  assign last_of_run_o = last_q;

endmodule

[sv/bmp_pixel_unpack_rotate_core.sv]
// ----------------------------------------------------------------------------
// BMP pixel unpack and rotate core
// Unpacks a bottom-up padded BMP pixel array and emits each pixel with its
// rotated, optionally mirrored screen coordinates.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake            | Carries
//   --------+-----------+----------------------+-------------------------------
//   in      | to core   | in_valid/in_ready    | palette write or data byte
//   out     | from core | out_valid/out_ready  | one pixel with coordinates
//   cfg     | to core   | cfg_valid/cfg_ready  | register index and write data
//
// The front takes one request per cycle while the four-entry job queue has
// room. The back emits one pixel per cycle while the output is not stalled;
// a byte yields one pixel at 8, up to two at 4 and up to eight at 1 bit per
// pixel, and three or four bytes make one pixel at 24 and 32 bits per pixel.
// The first pixel of a byte passes the job queue and the back end's output
// register before it can be taken at the output.
// Reset clears the position counters at once; there is no clearing pass and
// palette entries are undefined until written. A stalled output holds its
// pixel while the queue keeps absorbing requests until it is full.
module bmp_pixel_unpack_rotate_core
  import bpu_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [7:0]            palette_index_i,
  input  logic [7:0]            palette_red_i,
  input  logic [7:0]            palette_green_i,
  input  logic [7:0]            palette_blue_i,
  input  logic [7:0]            data_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_W-1:0]    screen_x_o,
  output logic [COORD_W-1:0]    screen_y_o,
  output logic [7:0]            red_o,
  output logic [7:0]            green_o,
  output logic [7:0]            blue_o,
  output logic                  last_of_run_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int DIM_W       = $clog2(MAX_DIMENSION + 1);
  localparam int CMP_W       = (DIM_W > 13) ? DIM_W : 13;
  localparam int QUEUE_DEPTH = 4;
  localparam int JOB_W       = $bits(job_t) + 2 * DIM_W;

  logic [2:0]       pixel_format_q;
  logic [12:0]      image_width_q;
  logic [12:0]      image_height_q;
  logic [1:0]       rotation_q;
  logic             mirror_enable_q;
  logic [13:0]      origin_x_q;
  logic [13:0]      origin_y_q;

  logic             cfg_write;
  logic             geom_clear;
  logic [CMP_W-1:0] width_ext, height_ext;
  logic [DIM_W-1:0] width_eff, height_eff;

  logic             push_valid, push_ready;
  job_t             push_job;
  logic [DIM_W-1:0] push_row, push_col;
  logic             pop_valid, pop_ready;
  logic [JOB_W-1:0] pop_data;
  job_t             pop_job;
  logic [DIM_W-1:0] pop_row, pop_col;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;
  // Any write to the image geometry restarts the image.
  assign geom_clear  = cfg_write & ((cfg_index_i == REG_PIXEL_FORMAT) ||
                                    (cfg_index_i == REG_IMAGE_WIDTH)  ||
                                    (cfg_index_i == REG_IMAGE_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q  <= FMT_8BPP;
      image_width_q   <= 13'd1;
      image_height_q  <= 13'd1;
      rotation_q      <= ROT_0;
      mirror_enable_q <= 1'b0;
      origin_x_q      <= '0;
      origin_y_q      <= '0;
    end else if (cfg_write) begin
      case (cfg_index_i)
        REG_PIXEL_FORMAT:  pixel_format_q  <= cfg_data_i[2:0];
        REG_IMAGE_WIDTH:   image_width_q   <= cfg_data_i[12:0];
        REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data_i[12:0];
        REG_ROTATION:      rotation_q      <= cfg_data_i[1:0];
        REG_MIRROR_ENABLE: mirror_enable_q <= cfg_data_i[0];
        REG_ORIGIN_X:      origin_x_q      <= cfg_data_i[13:0];
        REG_ORIGIN_Y:      origin_y_q      <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  assign width_ext  = CMP_W'(image_width_q);
  assign height_ext = CMP_W'(image_height_q);

  always_comb begin
    if (width_ext == '0) begin
      width_eff = DIM_W'(1);
    end else if (width_ext > CMP_W'(MAX_DIMENSION)) begin
      width_eff = DIM_W'(MAX_DIMENSION);
    end else begin
      width_eff = DIM_W'(width_ext);
    end
    if (height_ext == '0) begin
      height_eff = DIM_W'(1);
    end else if (height_ext > CMP_W'(MAX_DIMENSION)) begin
      height_eff = DIM_W'(MAX_DIMENSION);
    end else begin
      height_eff = DIM_W'(height_ext);
    end
  end

  bpu_front #(
    .DIM_W (DIM_W)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .clear_i         (geom_clear),
    .pixel_format_i  (pixel_format_q),
    .width_i         (width_eff),
    .height_i        (height_eff),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .palette_index_i (palette_index_i),
    .palette_red_i   (palette_red_i),
    .palette_green_i (palette_green_i),
    .palette_blue_i  (palette_blue_i),
    .data_byte_i     (data_byte_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_job_o      (push_job),
    .push_row_o      (push_row),
    .push_col_o      (push_col)
  );

  bpu_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_job, push_row, push_col}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign pop_job = job_t'(pop_data[JOB_W-1:2*DIM_W]);
  assign pop_row = pop_data[2*DIM_W-1:DIM_W];
  assign pop_col = pop_data[DIM_W-1:0];

  bpu_back #(
    .DIM_W         (DIM_W),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (pop_valid),
    .job_ready_o     (pop_ready),
    .job_i           (pop_job),
    .row_i           (pop_row),
    .col_i           (pop_col),
    .width_i         (width_eff),
    .height_i        (height_eff),
    .rotation_i      (rotation_q),
    .mirror_enable_i (mirror_enable_q),
    .origin_x_i      (origin_x_q),
    .origin_y_i      (origin_y_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .screen_x_o      (screen_x_o),
    .screen_y_o      (screen_y_o),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

[sim/bmp_pixel_unpack_rotate_tb.sv]
// ----------------------------------------------------------------------------
// BMP pixel unpack and rotate core testbench
// Drives palette writes and padded pixel bytes through a set of register
// settings, predicts every drawn pixel with its rotated coordinates and
// color, and checks the pixel stream in order under random flow control.
// ----------------------------------------------------------------------------
module testbench;
  import bpu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIMENSION = 4096;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 135;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SEND_GAPS,
    FLOW_RECV_STALLS,
    FLOW_BOTH
  } flow_e;

  typedef struct packed {
    logic       op;
    logic [7:0] pidx;
    logic [7:0] pr;
    logic [7:0] pg;
    logic [7:0] pb;
    logic [7:0] db;
  } request_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic               last;
  } pixel_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  op_i = 1'b0;
  logic [7:0]            palette_index_i = '0;
  logic [7:0]            palette_red_i = '0;
  logic [7:0]            palette_green_i = '0;
  logic [7:0]            palette_blue_i = '0;
  logic [7:0]            data_byte_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [COORD_W-1:0]    screen_x_o;
  logic [COORD_W-1:0]    screen_y_o;
  logic [7:0]            red_o;
  logic [7:0]            green_o;
  logic [7:0]            blue_o;
  logic                  last_of_run_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Register copies as the block holds them.
  logic [2:0]  cur_fmt = FMT_8BPP;
  logic [12:0] cur_width = 13'd1;
  logic [12:0] cur_height = 13'd1;
  logic [1:0]  cur_rot = ROT_0;
  logic        cur_mirror = 1'b0;
  logic [13:0] cur_org_x = '0;
  logic [13:0] cur_org_y = '0;

  // Position within the image and the pixel being assembled.
  logic [23:0] pal_mem [256];
  int unsigned pos_row = 0;
  int unsigned pos_col = 0;
  int unsigned pos_byte = 0;
  logic [23:0] part_rgb = '0;
  int unsigned part_cnt = 0;

  bit          pal_known [256];
  request_t    req_pending [$];
  pixel_t      pix_expect [$];
  reg_write_t  reg_plan [$];
  request_t    drv_req;
  pixel_t      mon_got;
  pixel_t      mon_want;
  flow_e       flow = FLOW_FREE;
  int          fault_count = 0;

  bmp_pixel_unpack_rotate_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .palette_index_i (palette_index_i),
    .palette_red_i   (palette_red_i),
    .palette_green_i (palette_green_i),
    .palette_blue_i  (palette_blue_i),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .screen_x_o      (screen_x_o),
    .screen_y_o      (screen_y_o),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .last_of_run_o   (last_of_run_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_size(logic [12:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIMENSION) return MAX_DIMENSION;
    return 32'(v);
  endfunction

  function automatic int unsigned pixel_bits();
    case (cur_fmt)
      FMT_1BPP:  return 1;
      FMT_4BPP:  return 4;
      FMT_24BPP: return 24;
      FMT_32BPP: return 32;
      default:   return 8;
    endcase
  endfunction

  // Rows are padded to a whole number of 32-bit words.
  function automatic int unsigned row_bytes();
    return ((pixel_bits() * clamp_size(cur_width) + 31) / 32) * 4;
  endfunction

  function automatic pixel_t place_pixel(int unsigned col, logic [23:0] rgb);
    int unsigned w, h, x, y;
    pixel_t p;
    w = clamp_size(cur_width);
    h = clamp_size(cur_height);
    case (cur_rot)
      ROT_0: begin
        x = cur_mirror ? cur_org_x + w - col : cur_org_x + col;
        y = cur_org_y + h - pos_row;
      end
      ROT_90: begin
        x = cur_org_x + h - pos_row;
        y = cur_mirror ? cur_org_y + col : cur_org_y + w - col;
      end
      ROT_180: begin
        x = cur_mirror ? cur_org_x + col : cur_org_x + w - col;
        y = cur_org_y + pos_row;
      end
      default: begin
        x = cur_org_x + pos_row;
        y = cur_mirror ? cur_org_y + w - col : cur_org_y + col;
      end
    endcase
    p.x = x[COORD_W-1:0];
    p.y = y[COORD_W-1:0];
    p.r = rgb[23:16];
    p.g = rgb[15:8];
    p.b = rgb[7:0];
    p.last = 1'b0;
    return p;
  endfunction

  task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PIXEL_FORMAT:  cur_fmt = data[2:0];
      REG_IMAGE_WIDTH:   cur_width = data[12:0];
      REG_IMAGE_HEIGHT:  cur_height = data[12:0];
      REG_ROTATION:      cur_rot = data[1:0];
      REG_MIRROR_ENABLE: cur_mirror = data[0];
      REG_ORIGIN_X:      cur_org_x = data[13:0];
      REG_ORIGIN_Y:      cur_org_y = data[13:0];
      default: ;
    endcase
    // A geometry change starts a new image; the palette survives.
    if (idx == REG_PIXEL_FORMAT || idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) begin
      pos_row = 0;
      pos_col = 0;
      pos_byte = 0;
      part_rgb = '0;
      part_cnt = 0;
    end
  endtask

  task automatic predict_request(request_t rq);
    int unsigned w, h, bits, per, n;
    logic [7:0] idx;
    pixel_t run [8];
    n = 0;
    if (!rq.op) begin
      pal_mem[rq.pidx] = {rq.pr, rq.pg, rq.pb};
      return;
    end
    w = clamp_size(cur_width);
    h = clamp_size(cur_height);
    bits = pixel_bits();
    if (bits >= 24) begin
      // Direct pixels arrive as blue, green, red and, at 32 bits, alpha.
      if (pos_col < w) begin
        case (part_cnt)
          0: begin
            part_rgb = {16'h0000, rq.db};
            part_cnt = 1;
          end
          1: begin
            part_rgb[15:8] = rq.db;
            part_cnt = 2;
          end
          2: begin
            run[n] = place_pixel(pos_col, {rq.db, part_rgb[15:0]});
            n++;
            if (bits == 24) begin
              part_cnt = 0;
              pos_col++;
            end else begin
              part_cnt = 3;
            end
          end
          default: begin
            part_cnt = 0;
            pos_col++;
          end
        endcase
      end
    end else begin
      per = 8 / bits;
      for (int k = 0; k < per && pos_col < w; k++) begin
        if (bits == 1) idx = {7'd0, rq.db[7-k]};
        else if (bits == 4) idx = (k == 0) ? {4'h0, rq.db[7:4]} : {4'h0, rq.db[3:0]};
        else idx = rq.db;
        run[n] = place_pixel(pos_col, pal_mem[idx]);
        n++;
        pos_col++;
      end
    end
    pos_byte++;
    if (pos_byte >= row_bytes()) begin
      pos_byte = 0;
      pos_col = 0;
      part_cnt = 0;
      part_rgb = '0;
      pos_row++;
      if (pos_row >= h) pos_row = 0;
    end
    if (n > 0) run[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) pix_expect.push_back(run[k]);
  endtask

  function automatic bit send_gap();
    case (flow)
      FLOW_SEND_GAPS: return $urandom_range(0, 99) < 56;
      FLOW_BOTH:      return $urandom_range(0, 99) < 19;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic bit recv_stall();
    case (flow)
      FLOW_RECV_STALLS: return $urandom_range(0, 99) < 56;
      FLOW_BOTH:        return $urandom_range(0, 99) < 19;
      default:          return 1'b0;
    endcase
  endfunction

  // Request driver: keeps valid and payload steady until the request is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_request({op_i, palette_index_i, palette_red_i, palette_green_i,
                         palette_blue_i, data_byte_i});
      end
      if (!in_valid_i || in_ready_o) begin
        if (req_pending.size() != 0 && !send_gap()) begin
          drv_req = req_pending.pop_front();
          in_valid_i      <= 1'b1;
          op_i            <= drv_req.op;
          palette_index_i <= drv_req.pidx;
          palette_red_i   <= drv_req.pr;
          palette_green_i <= drv_req.pg;
          palette_blue_i  <= drv_req.pb;
          data_byte_i     <= drv_req.db;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor: compares every accepted pixel with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        mon_got = {screen_x_o, screen_y_o, red_o, green_o, blue_o, last_of_run_o};
        if (pix_expect.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: unexpected pixel x=%0d y=%0d rgb=%h%h%h last=%0b", $realtime,
                     mon_got.x, mon_got.y, mon_got.r, mon_got.g, mon_got.b, mon_got.last);
        end else begin
          mon_want = pix_expect.pop_front();
          if (mon_got !== mon_want) begin
            fault_count++;
            if (fault_count <= 10)
              $display({"%0t: pixel mismatch: expected x=%0d y=%0d rgb=%h%h%h last=%0b,",
                        " got x=%0d y=%0d rgb=%h%h%h last=%0b"}, $realtime,
                       mon_want.x, mon_want.y, mon_want.r, mon_want.g, mon_want.b,
                       mon_want.last, mon_got.x, mon_got.y, mon_got.r, mon_got.g,
                       mon_got.b, mon_got.last);
          end
        end
      end
      out_ready_i <= !recv_stall();
    end
  end

  task automatic push_palette(logic [7:0] idx, logic [23:0] rgb);
    request_t rq;
    rq.op = 1'b0;
    rq.pidx = idx;
    {rq.pr, rq.pg, rq.pb} = rgb;
    rq.db = 8'($urandom);
    pal_known[idx] = 1'b1;
    req_pending.push_back(rq);
  endtask

  task automatic push_byte(logic [7:0] b);
    request_t rq;
    rq.op = 1'b1;
    rq.pidx = 8'($urandom);
    rq.pr = 8'($urandom);
    rq.pg = 8'($urandom);
    rq.pb = 8'($urandom);
    rq.db = b;
    req_pending.push_back(rq);
  endtask

  task automatic plan_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    reg_write_t wr;
    wr.idx = idx;
    wr.data = data;
    reg_plan.push_back(wr);
  endtask

  // Called at a clock edge with the block idle; valid stays high across
  // back-to-back writes.
  task automatic program_regs();
    reg_write_t wr;
    while (reg_plan.size() != 0) begin
      wr = reg_plan.pop_front();
      cfg_valid_i <= 1'b1;
      cfg_index_i <= wr.idx;
      cfg_data_i  <= wr.data;
      do @(posedge clk_i); while (!cfg_ready_o);
      apply_reg(wr.idx, wr.data);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (req_pending.size() != 0 || in_valid_i || pix_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Only palette entries that have been written may be looked up.
  function automatic bit byte_is_safe(logic [7:0] b);
    case (pixel_bits())
      1:       return pal_known[0] && pal_known[1];
      4:       return pal_known[b[7:4]] && pal_known[b[3:0]];
      8:       return pal_known[b];
      default: return 1'b1;
    endcase
  endfunction

  function automatic logic [7:0] pick_pixel_byte();
    logic [7:0] b;
    for (int t = 0; t < 256; t++) begin
      b = 8'($urandom);
      if (byte_is_safe(b)) return b;
    end
    return 8'h00;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_origin();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  initial begin
    int phase, random_items, n_bytes;
    logic [2:0] fmt;
    logic [CFG_DATA_W-1:0] size;
    phase = 0;
    random_items = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: 8 bits per pixel, one pixel by one row.
    push_palette(8'h00, 24'h000000);
    push_palette(8'hFF, 24'hFFFFFF);
    push_palette(8'h01, 24'hFF00FF);
    push_palette(8'h80, 24'h00FF00);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h80);
    wait_drained();

    // 1 bit per pixel, oversized width clamps, zero height clamps, plus a
    // write to an index past the register list.
    plan_reg(REG_UNUSED, '1);
    plan_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_1BPP));
    plan_reg(REG_IMAGE_WIDTH, 14'h1FFF);
    plan_reg(REG_IMAGE_HEIGHT, '0);
    plan_reg(REG_ROTATION, CFG_DATA_W'(ROT_270));
    plan_reg(REG_MIRROR_ENABLE, 14'd1);
    plan_reg(REG_ORIGIN_X, '1);
    plan_reg(REG_ORIGIN_Y, '1);
    program_regs();
    push_byte(8'hA5);
    push_byte(8'h5A);
    wait_drained();

    // An unused format code behaves as 8 bits per pixel; zero width clamps.
    plan_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_32BPP + 3'd3));
    plan_reg(REG_IMAGE_WIDTH, '0);
    plan_reg(REG_ROTATION, CFG_DATA_W'(ROT_90));
    plan_reg(REG_MIRROR_ENABLE, '0);
    plan_reg(REG_ORIGIN_X, '0);
    plan_reg(REG_ORIGIN_Y, '0);
    program_regs();
    push_byte(8'h01);
    push_byte(8'hAA);
    push_byte(8'h55);
    push_byte(8'h80);
    wait_drained();

    plan_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_24BPP));
    plan_reg(REG_IMAGE_WIDTH, 14'd1);
    plan_reg(REG_IMAGE_HEIGHT, 14'd2);
    plan_reg(REG_ROTATION, CFG_DATA_W'(ROT_180));
    plan_reg(REG_MIRROR_ENABLE, 14'd1);
    program_regs();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(8'h7F);
    wait_drained();

    // Largest image at the far corner; the alpha byte draws nothing.
    plan_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_32BPP));
    plan_reg(REG_IMAGE_WIDTH, 14'd4096);
    plan_reg(REG_IMAGE_HEIGHT, 14'd4096);
    plan_reg(REG_ROTATION, CFG_DATA_W'(ROT_0));
    plan_reg(REG_MIRROR_ENABLE, '0);
    plan_reg(REG_ORIGIN_X, '1);
    plan_reg(REG_ORIGIN_Y, '1);
    program_regs();
    push_byte(8'hFF);
    push_byte(8'h01);
    push_byte(8'hFE);
    push_byte(8'h00);
    wait_drained();

    // Fill the low sixteen entries and a random spread of the rest.
    for (int k = 0; k < 16; k++) push_palette(8'(k), 24'($urandom));
    repeat (48) push_palette(8'($urandom), 24'($urandom));
    wait_drained();

    while (random_items < RANDOM_ITEMS) begin
      flow = flow_e'(phase % 4);
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0, 1:    fmt = FMT_1BPP;
          2, 3:    fmt = FMT_4BPP;
          4:       fmt = FMT_8BPP;
          5, 6:    fmt = FMT_24BPP;
          7, 8:    fmt = FMT_32BPP;
          default: fmt = FMT_32BPP + 3'($urandom_range(1, 3));
        endcase
        plan_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(fmt));
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       size = '0;
          1:       size = CFG_DATA_W'($urandom_range(4097, 16383));
          2:       size = CFG_DATA_W'($urandom_range(100, 4096));
          default: size = CFG_DATA_W'($urandom_range(1, 12));
        endcase
        plan_reg(REG_IMAGE_WIDTH, size);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       size = '0;
          1:       size = CFG_DATA_W'($urandom);
          default: size = CFG_DATA_W'($urandom_range(1, 4));
        endcase
        plan_reg(REG_IMAGE_HEIGHT, size);
      end
      if ($urandom_range(0, 3) != 0) plan_reg(REG_ROTATION, CFG_DATA_W'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) != 0) plan_reg(REG_MIRROR_ENABLE, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 3) != 0) plan_reg(REG_ORIGIN_X, pick_origin());
      if ($urandom_range(0, 3) != 0) plan_reg(REG_ORIGIN_Y, pick_origin());
      if ($urandom_range(0, 9) == 0) plan_reg(REG_UNUSED, CFG_DATA_W'($urandom));
      program_regs();

      // Mostly one or two whole images; now and then a sequence cut short.
      n_bytes = row_bytes() * clamp_size(cur_height) * $urandom_range(1, 2);
      if (n_bytes > 40) n_bytes = $urandom_range(8, 40);
      if ($urandom_range(0, 9) == 0) n_bytes = $urandom_range(1, n_bytes);
      for (int k = 0; k < n_bytes; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          push_palette(8'($urandom), 24'($urandom));
          random_items++;
        end
        push_byte(pick_pixel_byte());
        random_items++;
      end
      wait_drained();
      phase++;
    end

    if (fault_count == 0 && pix_expect.size() == 0) begin
      $display("bmp_pixel_unpack_rotate_core verification clean");
    end else begin
      $display("bmp_pixel_unpack_rotate_core verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("bmp_pixel_unpack_rotate_core verification failed");
    $finish;
  end

endmodule

[filelist.f]
sv/bpu_pkg.sv
sv/bpu_fifo.sv
sv/bpu_front.sv
sv/bpu_back.sv
sv/bmp_pixel_unpack_rotate_core.sv
sim/bmp_pixel_unpack_rotate_tb.sv
